### hdl/tsrcc_pkg.sv
package tsrcc_pkg;

  // Field widths of the frame, the registers and the result word.
  localparam int unsigned FrameIdW   = 11;
  localparam int unsigned CmdW       = 8;
  localparam int unsigned AngleW     = 12;
  localparam int unsigned DegW       = 8;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 12;
  localparam int unsigned InDataW    = 24;
  localparam int unsigned OutDataW   = 24;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CFG_NODE_ID      = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_STEP_SIZE    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_CLOSE_FIRST  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_CLOSE_SECOND = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_OPEN_ANGLE   = 3'd4;

  // Command byte codes.
  localparam logic [CmdW-1:0] CMD_CLOSE_FIRST  = 8'h00;
  localparam logic [CmdW-1:0] CMD_OPEN_FIRST   = 8'h01;
  localparam logic [CmdW-1:0] CMD_STOP_FIRST   = 8'h02;
  localparam logic [CmdW-1:0] CMD_CLOSE_SECOND = 8'h10;
  localparam logic [CmdW-1:0] CMD_OPEN_SECOND  = 8'h11;
  localparam logic [CmdW-1:0] CMD_STOP_SECOND  = 8'h12;

  // Completion message codes.
  localparam logic [7:0] DONE_CODE_FIRST  = 8'h40;
  localparam logic [7:0] DONE_CODE_SECOND = 8'h41;

  // Reset values, angles in 1/16 degree.
  localparam logic [FrameIdW-1:0] NODE_ID_RST      = 11'd1024;
  localparam logic [AngleW-1:0]   STEP_SIZE_RST    = 12'd80;
  localparam logic [AngleW-1:0]   CLOSE_FIRST_RST  = 12'd800;
  localparam logic [AngleW-1:0]   CLOSE_SECOND_RST = 12'd1280;
  localparam logic [AngleW-1:0]   OPEN_ANGLE_RST   = 12'd0;
  localparam logic [AngleW-1:0]   HOME_ANGLE       = 12'd1280;

  // A hand closer than half a degree snaps to its goal.
  localparam logic [AngleW-1:0]   SNAP_UNITS       = 12'd8;

  typedef enum logic [2:0] {
    ST_OPENING    = 3'd0,
    ST_CLOSING    = 3'd1,
    ST_STOPPED    = 3'd2,
    ST_OPEN_DONE  = 3'd3,
    ST_CLOSE_DONE = 3'd4
  } hand_state_e;

  // Per-hand result of one update.
  typedef struct packed {
    logic            angle_valid;
    logic [DegW-1:0] servo_angle;
    hand_state_e     hand_state;
    logic            done_valid;
    logic [7:0]      done_code;
    logic            done_opened;
  } hand_res_t;

endpackage

### hdl/two_servo_ramp_command_controller.sv
// The first result word (hand one) is valid in the cycle after a frame is accepted,
// the second (hand two, tlast high) follows when the first is taken.
// Each frame gives two result words on the single output port, so output stalls hold
// back the input; a new frame is taken while the second word is being delivered.
// Reset (rst_ni low, asynchronous): configuration and hand registers return to their defaults, both hands stopped
// at 80 degrees with goal 80 degrees, and the output is empty.
module two_servo_ramp_command_controller (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write port.
  input  logic                               cfg_we_i,
  input  logic [tsrcc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [tsrcc_pkg::CfgDataW-1:0]     cfg_data_i,
  // Frame input.
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // Fields from bit 0: frame_id[10:0], command_byte[18:11], zero pad.
  input  logic [tsrcc_pkg::InDataW-1:0]      s_axis_tdata_i,
  // Result output.
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // Fields from bit 0: angle_valid[0], servo_angle[8:1], hand_state[11:9],
  // done_valid[12], done_code[20:13], done_opened[21], zero pad.
  output logic [tsrcc_pkg::OutDataW-1:0]     m_axis_tdata_o,
  // Fields from bit 0: hand_index.
  output logic                               m_axis_tuser_o,
  output logic                               m_axis_tlast_o
);

  logic [tsrcc_pkg::FrameIdW-1:0] node_id_q;
  logic [tsrcc_pkg::AngleW-1:0]   step_size_q;
  logic [tsrcc_pkg::AngleW-1:0]   close_first_q;
  logic [tsrcc_pkg::AngleW-1:0]   close_second_q;
  logic [tsrcc_pkg::AngleW-1:0]   open_angle_q;

  logic [tsrcc_pkg::AngleW-1:0]   present_q [2];
  logic [tsrcc_pkg::AngleW-1:0]   goal_q    [2];
  tsrcc_pkg::hand_state_e         state_q   [2];

  logic [tsrcc_pkg::AngleW-1:0]   goal_d    [2];
  tsrcc_pkg::hand_state_e         st_cmd    [2];
  logic [tsrcc_pkg::AngleW-1:0]   present_d [2];
  tsrcc_pkg::hand_state_e         state_d   [2];
  tsrcc_pkg::hand_res_t           res_d     [2];
  tsrcc_pkg::hand_res_t           res_q     [2];
  tsrcc_pkg::hand_res_t           res_out;

  logic                           out_valid_q;
  logic                           sel_q;
  logic                           in_acc;
  logic                           out_acc;
  logic [tsrcc_pkg::FrameIdW-1:0] frame_id;
  logic [tsrcc_pkg::CmdW-1:0]     command_byte;

  assign frame_id     = s_axis_tdata_i[10:0];
  assign command_byte = s_axis_tdata_i[18:11];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q      <= tsrcc_pkg::NODE_ID_RST;
      step_size_q    <= tsrcc_pkg::STEP_SIZE_RST;
      close_first_q  <= tsrcc_pkg::CLOSE_FIRST_RST;
      close_second_q <= tsrcc_pkg::CLOSE_SECOND_RST;
      open_angle_q   <= tsrcc_pkg::OPEN_ANGLE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tsrcc_pkg::CFG_NODE_ID:      node_id_q      <= cfg_data_i[tsrcc_pkg::FrameIdW-1:0];
        tsrcc_pkg::CFG_STEP_SIZE:    step_size_q    <= cfg_data_i;
        tsrcc_pkg::CFG_CLOSE_FIRST:  close_first_q  <= cfg_data_i;
        tsrcc_pkg::CFG_CLOSE_SECOND: close_second_q <= cfg_data_i;
        tsrcc_pkg::CFG_OPEN_ANGLE:   open_angle_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Command decode: a matching frame with a known command changes the goal and state of one hand.
  always_comb begin
    goal_d[0] = goal_q[0];
    goal_d[1] = goal_q[1];
    st_cmd[0] = state_q[0];
    st_cmd[1] = state_q[1];
    if (frame_id == node_id_q) begin
      unique case (command_byte)
        tsrcc_pkg::CMD_CLOSE_FIRST: begin
          goal_d[0] = close_first_q;
          st_cmd[0] = tsrcc_pkg::ST_CLOSING;
        end
        tsrcc_pkg::CMD_OPEN_FIRST: begin
          goal_d[0] = open_angle_q;
          st_cmd[0] = tsrcc_pkg::ST_OPENING;
        end
        tsrcc_pkg::CMD_STOP_FIRST: begin
          goal_d[0] = present_q[0];
          st_cmd[0] = tsrcc_pkg::ST_STOPPED;
        end
        tsrcc_pkg::CMD_CLOSE_SECOND: begin
          goal_d[1] = close_second_q;
          st_cmd[1] = tsrcc_pkg::ST_CLOSING;
        end
        tsrcc_pkg::CMD_OPEN_SECOND: begin
          goal_d[1] = open_angle_q;
          st_cmd[1] = tsrcc_pkg::ST_OPENING;
        end
        tsrcc_pkg::CMD_STOP_SECOND: begin
          goal_d[1] = present_q[1];
          st_cmd[1] = tsrcc_pkg::ST_STOPPED;
        end
        default: ;
      endcase
    end
  end

  // Ramp update of both hands.
  tsrcc_hand u_hand0 (
    .hand_i (1'b0),
    .cur_i  (present_q[0]),
    .tgt_i  (goal_d[0]),
    .step_i (step_size_q),
    .st_i   (st_cmd[0]),
    .cur_o  (present_d[0]),
    .st_o   (state_d[0]),
    .res_o  (res_d[0])
  );

  tsrcc_hand u_hand1 (
    .hand_i (1'b1),
    .cur_i  (present_q[1]),
    .tgt_i  (goal_d[1]),
    .step_i (step_size_q),
    .st_i   (st_cmd[1]),
    .cur_o  (present_d[1]),
    .st_o   (state_d[1]),
    .res_o  (res_d[1])
  );

  // Handshake: take a frame when the result pair is empty or its last word leaves now.
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc         = m_axis_tvalid_o && m_axis_tready_i;
  assign s_axis_tready_o = !out_valid_q || (sel_q && m_axis_tready_i);

  // Hand state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q[0] <= tsrcc_pkg::HOME_ANGLE;
      present_q[1] <= tsrcc_pkg::HOME_ANGLE;
      goal_q[0]    <= tsrcc_pkg::HOME_ANGLE;
      goal_q[1]    <= tsrcc_pkg::HOME_ANGLE;
      state_q[0]   <= tsrcc_pkg::ST_STOPPED;
      state_q[1]   <= tsrcc_pkg::ST_STOPPED;
    end else if (in_acc) begin
      present_q[0] <= present_d[0];
      present_q[1] <= present_d[1];
      goal_q[0]    <= goal_d[0];
      goal_q[1]    <= goal_d[1];
      state_q[0]   <= state_d[0];
      state_q[1]   <= state_d[1];
    end
  end

  // Result pair, payload only.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q[0] <= res_d[0];
      res_q[1] <= res_d[1];
    end
  end

  // Output control: valid flag and which word of the pair is shown.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sel_q       <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
      sel_q       <= 1'b0;
    end else if (out_acc) begin
      if (sel_q) begin
        out_valid_q <= 1'b0;
      end else begin
        sel_q <= 1'b1;
      end
    end
  end

  // Output word packing.
  assign res_out         = sel_q ? res_q[1] : res_q[0];
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = sel_q;
  assign m_axis_tlast_o  = sel_q;
  assign m_axis_tdata_o  = {2'b00,
                            res_out.done_opened,
                            res_out.done_code,
                            res_out.done_valid,
                            res_out.hand_state,
                            res_out.servo_angle,
                            res_out.angle_valid};

`ifndef NO_ASSERTIONS
  // A new frame never overwrites a pair whose first word is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !(out_valid_q && !sel_q))
    else $error("frame accepted while hand one word pending");

  // An accepted frame shows the hand one word in the next cycle.
  a_first_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (m_axis_tvalid_o && !sel_q))
    else $error("hand one word not presented after accept");

  // A hand at rest always sits exactly on its goal.
  a_rest_hand0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q[0] != tsrcc_pkg::ST_OPENING && state_q[0] != tsrcc_pkg::ST_CLOSING)
      |-> (present_q[0] == goal_q[0]))
    else $error("hand one at rest off its goal");

  a_rest_hand1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q[1] != tsrcc_pkg::ST_OPENING && state_q[1] != tsrcc_pkg::ST_CLOSING)
      |-> (present_q[1] == goal_q[1]))
    else $error("hand two at rest off its goal");

  // A completion is only reported together with an angle.
  a_done_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[12]) |-> m_axis_tdata_o[0])
    else $error("completion without angle");
`endif

endmodule

### hdl/tsrcc_hand.sv
module tsrcc_hand (
  input  logic                                hand_i,
  input  logic [tsrcc_pkg::AngleW-1:0]        cur_i,
  input  logic [tsrcc_pkg::AngleW-1:0]        tgt_i,
  input  logic [tsrcc_pkg::AngleW-1:0]        step_i,
  input  tsrcc_pkg::hand_state_e              st_i,
  output logic [tsrcc_pkg::AngleW-1:0]        cur_o,
  output tsrcc_pkg::hand_state_e              st_o,
  output tsrcc_pkg::hand_res_t                res_o
);

  logic                               moving;
  logic                               up;
  logic                               snap;
  logic [tsrcc_pkg::AngleW-1:0]       gap;
  logic [tsrcc_pkg::AngleW-1:0]       mv;
  logic [tsrcc_pkg::AngleW:0]         deg_sum;
  logic [tsrcc_pkg::AngleW-4:0]       deg_full;
  logic [tsrcc_pkg::DegW-1:0]         deg;

  // Distance to the goal and the move limited by the step size.
  assign moving = (st_i == tsrcc_pkg::ST_OPENING) || (st_i == tsrcc_pkg::ST_CLOSING);
  assign up     = tgt_i >= cur_i;
  assign gap    = up ? (tgt_i - cur_i) : (cur_i - tgt_i);
  assign snap   = gap < tsrcc_pkg::SNAP_UNITS;
  assign mv     = (gap < step_i) ? gap : step_i;

  // Next state and next angle of the hand.
  always_comb begin
    st_o  = st_i;
    cur_o = cur_i;
    if (moving) begin
      if (snap) begin
        cur_o = tgt_i;
        st_o  = (st_i == tsrcc_pkg::ST_OPENING) ? tsrcc_pkg::ST_OPEN_DONE
                                                : tsrcc_pkg::ST_CLOSE_DONE;
      end else begin
        cur_o = up ? (cur_i + mv) : (cur_i - mv);
      end
    end
  end

  // Whole degrees, rounded half up, saturated to a byte.
  assign deg_sum  = {1'b0, cur_o} + 13'd8;
  assign deg_full = deg_sum[tsrcc_pkg::AngleW:4];
  assign deg      = (deg_full > 9'd255) ? 8'd255 : deg_full[tsrcc_pkg::DegW-1:0];

  // Result word of this hand.
  always_comb begin
    res_o             = '0;
    res_o.hand_state  = st_o;
    if (moving) begin
      res_o.angle_valid = 1'b1;
      res_o.servo_angle = deg;
      if (snap) begin
        res_o.done_valid  = 1'b1;
        res_o.done_code   = hand_i ? tsrcc_pkg::DONE_CODE_SECOND : tsrcc_pkg::DONE_CODE_FIRST;
        res_o.done_opened = (st_i == tsrcc_pkg::ST_OPENING);
      end
    end
  end

endmodule

### sim/tb_two_servo_ramp_command_controller.sv
`timescale 1ns / 100ps

module tb_two_servo_ramp_command_controller;

  // Field widths taken over from the package.
  localparam int unsigned FrameIdW = tsrcc_pkg::FrameIdW;
  localparam int unsigned CmdW     = tsrcc_pkg::CmdW;
  localparam int unsigned AngleW   = tsrcc_pkg::AngleW;
  localparam int unsigned CfgIdxW  = tsrcc_pkg::CfgIdxW;
  localparam int unsigned CfgDataW = tsrcc_pkg::CfgDataW;
  localparam int unsigned InDataW  = tsrcc_pkg::InDataW;
  localparam int unsigned OutDataW = tsrcc_pkg::OutDataW;

  // One bus frame as it sits in the input word, frame id in the low bits.
  typedef struct packed {
    logic [CmdW-1:0]     command;
    logic [FrameIdW-1:0] frame_id;
  } frame_t;

  // One result word with its sideband bits.
  typedef struct packed {
    logic                 hand;
    logic                 last;
    tsrcc_pkg::hand_res_t res;
  } servo_word_t;

  // Indexes past the register list; writes to them must change nothing.
  localparam logic [CfgIdxW-1:0] CFG_SPARE_IDX = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_TOP_IDX   = 3'd7;

  localparam int unsigned NumPhases   = 8;
  localparam int unsigned PhaseFrames = 235;
  localparam int unsigned HoldAfter   = 100;
  localparam int unsigned HoldCycles  = 200;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned MaxReports  = 10;
  localparam int unsigned LimitCycles = 200000;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                cfg_we_i        = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i       = tsrcc_pkg::CFG_NODE_ID;
  logic [CfgDataW-1:0] cfg_data_i      = '0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  // Fields from bit 0: frame_id[10:0], command_byte[18:11], zero pad.
  logic [InDataW-1:0]  s_axis_tdata_i  = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  // Fields from bit 0: angle_valid, servo_angle, hand_state, done_valid,
  // done_code, done_opened, zero pad.
  logic [OutDataW-1:0] m_axis_tdata_o;
  // Fields from bit 0: hand_index.
  logic                m_axis_tuser_o;
  logic                m_axis_tlast_o;

  // Frames waiting to be offered, and result words still owed by the block.
  frame_t      frames_to_send[$];
  servo_word_t ramp_results_q[$];

  // Shadow copy of the registers and of both hands.
  logic [FrameIdW-1:0]   node_id_m      = tsrcc_pkg::NODE_ID_RST;
  logic [AngleW-1:0]     step_m         = tsrcc_pkg::STEP_SIZE_RST;
  logic [AngleW-1:0]     close_first_m  = tsrcc_pkg::CLOSE_FIRST_RST;
  logic [AngleW-1:0]     close_second_m = tsrcc_pkg::CLOSE_SECOND_RST;
  logic [AngleW-1:0]     open_m         = tsrcc_pkg::OPEN_ANGLE_RST;
  logic [AngleW-1:0]     angle_m[2]     = '{tsrcc_pkg::HOME_ANGLE, tsrcc_pkg::HOME_ANGLE};
  logic [AngleW-1:0]     goal_m[2]      = '{tsrcc_pkg::HOME_ANGLE, tsrcc_pkg::HOME_ANGLE};
  tsrcc_pkg::hand_state_e motion_m[2]   = '{tsrcc_pkg::ST_STOPPED, tsrcc_pkg::ST_STOPPED};

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned frames_in      = 0;
  int unsigned error_cnt      = 0;
  int unsigned hold_left      = 0;
  bit          hold_used      = 1'b0;
  bit          frame_taken    = 1'b0;

  always #6 clk_i = ~clk_i;

  two_servo_ramp_command_controller i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // Apply one frame to the shadow hands and queue the two result words it causes.
  task automatic ramp_hands(input frame_t f);
    servo_word_t      w;
    int unsigned      gap;
    int unsigned      stride;
    int unsigned      deg;
    logic [AngleW-1:0] cur;
    logic [AngleW-1:0] tgt;
    if (f.frame_id == node_id_m) begin
      case (f.command)
        tsrcc_pkg::CMD_CLOSE_FIRST: begin
          goal_m[0] = close_first_m;
          motion_m[0] = tsrcc_pkg::ST_CLOSING;
        end
        tsrcc_pkg::CMD_OPEN_FIRST: begin
          goal_m[0] = open_m;
          motion_m[0] = tsrcc_pkg::ST_OPENING;
        end
        tsrcc_pkg::CMD_STOP_FIRST: begin
          goal_m[0] = angle_m[0];
          motion_m[0] = tsrcc_pkg::ST_STOPPED;
        end
        tsrcc_pkg::CMD_CLOSE_SECOND: begin
          goal_m[1] = close_second_m;
          motion_m[1] = tsrcc_pkg::ST_CLOSING;
        end
        tsrcc_pkg::CMD_OPEN_SECOND: begin
          goal_m[1] = open_m;
          motion_m[1] = tsrcc_pkg::ST_OPENING;
        end
        tsrcc_pkg::CMD_STOP_SECOND: begin
          goal_m[1] = angle_m[1];
          motion_m[1] = tsrcc_pkg::ST_STOPPED;
        end
        default: begin
        end
      endcase
    end
    for (int h = 0; h < 2; h++) begin
      w = '0;
      w.hand = (h == 1);
      w.last = (h == 1);
      if (motion_m[h] == tsrcc_pkg::ST_OPENING || motion_m[h] == tsrcc_pkg::ST_CLOSING) begin
        cur = angle_m[h];
        tgt = goal_m[h];
        gap = (tgt >= cur) ? int'(tgt - cur) : int'(cur - tgt);
        if (gap < tsrcc_pkg::SNAP_UNITS) begin
          // Close enough: snap onto the goal and report completion.
          angle_m[h] = tgt;
          motion_m[h] = (motion_m[h] == tsrcc_pkg::ST_OPENING) ? tsrcc_pkg::ST_OPEN_DONE
                                                               : tsrcc_pkg::ST_CLOSE_DONE;
          w.res.done_valid  = 1'b1;
          w.res.done_code   = (h == 1) ? tsrcc_pkg::DONE_CODE_SECOND
                                       : tsrcc_pkg::DONE_CODE_FIRST;
          w.res.done_opened = (motion_m[h] == tsrcc_pkg::ST_OPEN_DONE);
        end else begin
          stride = (gap < step_m) ? gap : int'(step_m);
          angle_m[h] = (tgt >= cur) ? AngleW'(cur + stride) : AngleW'(cur - stride);
        end
        // Round half up to whole degrees and clip to the output width.
        deg = (int'(angle_m[h]) + 8) >> 4;
        w.res.angle_valid = 1'b1;
        w.res.servo_angle = (deg > 255) ? 8'd255 : deg[7:0];
      end
      w.res.hand_state = motion_m[h];
      ramp_results_q.push_back(w);
    end
  endtask

  task automatic report_mismatch(input string what, input servo_word_t want,
                                 input servo_word_t got);
    error_cnt++;
    if (error_cnt <= MaxReports) begin
      $display("%0t: %s", $realtime, what);
      $display("  want hand %0d last %0d av %0d deg %0d st %0d dv %0d code %h open %0d",
               want.hand, want.last, want.res.angle_valid, want.res.servo_angle,
               want.res.hand_state, want.res.done_valid, want.res.done_code,
               want.res.done_opened);
      $display("  got  hand %0d last %0d av %0d deg %0d st %0d dv %0d code %h open %0d",
               got.hand, got.last, got.res.angle_valid, got.res.servo_angle,
               got.res.hand_state, got.res.done_valid, got.res.done_code,
               got.res.done_opened);
    end
  endtask

  // Track register writes, predict accepted frames and check result words.
  always @(posedge clk_i) begin : result_monitor
    servo_word_t got;
    servo_word_t want;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        tsrcc_pkg::CFG_NODE_ID:      node_id_m      = cfg_data_i[FrameIdW-1:0];
        tsrcc_pkg::CFG_STEP_SIZE:    step_m         = cfg_data_i[AngleW-1:0];
        tsrcc_pkg::CFG_CLOSE_FIRST:  close_first_m  = cfg_data_i[AngleW-1:0];
        tsrcc_pkg::CFG_CLOSE_SECOND: close_second_m = cfg_data_i[AngleW-1:0];
        tsrcc_pkg::CFG_OPEN_ANGLE:   open_m         = cfg_data_i[AngleW-1:0];
        default: begin
        end
      endcase
    end
    frame_taken = s_axis_tvalid_i && s_axis_tready_o;
    if (frame_taken) begin
      frames_in++;
      ramp_hands(frame_t'(s_axis_tdata_i[FrameIdW+CmdW-1:0]));
    end
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got.hand            = m_axis_tuser_o;
      got.last            = m_axis_tlast_o;
      got.res.angle_valid = m_axis_tdata_o[0];
      got.res.servo_angle = m_axis_tdata_o[8:1];
      got.res.hand_state  = tsrcc_pkg::hand_state_e'(m_axis_tdata_o[11:9]);
      got.res.done_valid  = m_axis_tdata_o[12];
      got.res.done_code   = m_axis_tdata_o[20:13];
      got.res.done_opened = m_axis_tdata_o[21];
      if (ramp_results_q.size() == 0) begin
        report_mismatch("result word with nothing outstanding", '0, got);
      end else begin
        want = ramp_results_q.pop_front();
        if (got !== want) begin
          report_mismatch("result word differs", want, got);
        end
      end
    end
  end

  // Offer the next frame once the current word is taken, idling at random.
  always @(negedge clk_i) begin : frame_driver
    frame_t nxt;
    if (!s_axis_tvalid_i || frame_taken) begin
      if (frames_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = frames_to_send.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= {{(InDataW - FrameIdW - CmdW){1'b0}}, nxt};
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Result side: random stalls, plus one long hold-off so the input backs up.
  always @(negedge clk_i) begin : result_sink
    if (hold_left != 0) begin
      m_axis_tready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_used && frames_in >= HoldAfter) begin
      hold_used <= 1'b1;
      hold_left <= HoldCycles;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val[CfgDataW-1:0];
  endtask

  // Wait until no frame is queued or offered and every result word is taken.
  task automatic wait_idle();
    while (frames_to_send.size() != 0 || s_axis_tvalid_i || ramp_results_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (2) @(posedge clk_i);
  endtask

  function automatic logic [CmdW-1:0] pick_command();
    case ($urandom_range(5))
      0:       return tsrcc_pkg::CMD_CLOSE_FIRST;
      1:       return tsrcc_pkg::CMD_OPEN_FIRST;
      2:       return tsrcc_pkg::CMD_STOP_FIRST;
      3:       return tsrcc_pkg::CMD_CLOSE_SECOND;
      4:       return tsrcc_pkg::CMD_OPEN_SECOND;
      default: return tsrcc_pkg::CMD_STOP_SECOND;
    endcase
  endfunction

  // A frame that is mostly a command for this node, then a run of up to twelve frames
  // with random ids and bytes, so that moving hands get room to ramp towards their goals.
  task automatic queue_burst(inout int unsigned n);
    frame_t f;
    int unsigned k;
    f.frame_id = ($urandom_range(99) < 90) ? node_id_m : FrameIdW'($urandom_range(2047));
    f.command  = ($urandom_range(99) < 85) ? pick_command() : CmdW'($urandom_range(255));
    frames_to_send.push_back(f);
    k = $urandom_range(12);
    repeat (k) begin
      f.frame_id = FrameIdW'($urandom_range(2047));
      f.command  = CmdW'($urandom_range(255));
      frames_to_send.push_back(f);
    end
    n += k + 1;
  endtask

  initial begin : stimulus
    frame_t      f;
    int unsigned n;
    int unsigned v[5];
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed frames with the reset settings: every command, unknown bytes,
    // frames for other nodes and a long run to let hand one open fully.
    f.frame_id = tsrcc_pkg::NODE_ID_RST;
    f.command = tsrcc_pkg::CMD_CLOSE_FIRST;  frames_to_send.push_back(f);
    f.command = tsrcc_pkg::CMD_CLOSE_SECOND; frames_to_send.push_back(f);
    f.command = tsrcc_pkg::CMD_STOP_FIRST;   frames_to_send.push_back(f);
    f.command = tsrcc_pkg::CMD_OPEN_FIRST;   frames_to_send.push_back(f);
    f.command = 8'h03;            frames_to_send.push_back(f);
    f.command = 8'h0F;            frames_to_send.push_back(f);
    f.command = 8'h13;            frames_to_send.push_back(f);
    f.command = 8'hFF;            frames_to_send.push_back(f);
    f.frame_id = 11'h3FF; f.command = tsrcc_pkg::CMD_OPEN_SECOND; frames_to_send.push_back(f);
    f.frame_id = 11'h000; f.command = tsrcc_pkg::CMD_CLOSE_FIRST; frames_to_send.push_back(f);
    f.frame_id = 11'h7FF; f.command = tsrcc_pkg::CMD_OPEN_SECOND; frames_to_send.push_back(f);
    f.frame_id = tsrcc_pkg::NODE_ID_RST;
    f.command = tsrcc_pkg::CMD_OPEN_SECOND;  frames_to_send.push_back(f);
    f.command = tsrcc_pkg::CMD_STOP_SECOND;  frames_to_send.push_back(f);
    f.command = tsrcc_pkg::CMD_CLOSE_SECOND; frames_to_send.push_back(f);
    f.frame_id = 11'h7FF; f.command = 8'hFF;
    repeat (12) frames_to_send.push_back(f);
    wait_idle();

    // Random phases, each with its own register settings, cycling through four idling patterns.
    for (int unsigned p = 0; p < NumPhases; p++) begin
      case (p)
        0:       v = '{tsrcc_pkg::NODE_ID_RST, tsrcc_pkg::STEP_SIZE_RST,
                       tsrcc_pkg::CLOSE_FIRST_RST, tsrcc_pkg::CLOSE_SECOND_RST,
                       tsrcc_pkg::OPEN_ANGLE_RST};
        1:       v = '{0, 0, 0, 2880, 2880};
        2:       v = '{12'hFFF, 2880, 2880, 0, 0};
        3:       v = '{5, 1, 1300, 1270, 1285};
        4:       v = '{1024, 4095, 4095, 4080, 4072};
        default: v = '{$urandom_range(4095), $urandom_range(1, 300), $urandom_range(2880),
                       $urandom_range(2880), $urandom_range(2880)};
      endcase
      write_reg(tsrcc_pkg::CFG_NODE_ID, v[0]);
      write_reg(tsrcc_pkg::CFG_STEP_SIZE, v[1]);
      write_reg(tsrcc_pkg::CFG_CLOSE_FIRST, v[2]);
      write_reg(tsrcc_pkg::CFG_CLOSE_SECOND, v[3]);
      write_reg(tsrcc_pkg::CFG_OPEN_ANGLE, v[4]);
      if (p == 3) begin
        write_reg(CFG_SPARE_IDX, 12'hABC);
      end
      if (p == 6) begin
        write_reg(CFG_TOP_IDX, 12'h001);
      end
      @(negedge clk_i);
      cfg_we_i <= 1'b0;
      @(posedge clk_i);

      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      n = 0;
      while (n < PhaseFrames) begin
        queue_burst(n);
      end
      wait_idle();
    end

    // Give the block time to show any stray word before the verdict.
    repeat (SettleCycles) @(posedge clk_i);
    if (error_cnt == 0 && ramp_results_q.size() == 0) begin
      $display("PASS two_servo_ramp_command_controller");
    end else begin
      $display("FAIL two_servo_ramp_command_controller");
    end
    $finish;
  end

  initial begin : watchdog
    #(12.0 * LimitCycles);
    $display("FAIL two_servo_ramp_command_controller");
    $finish;
  end

endmodule
